FILE: rtl/core/sfpp_pkg.sv
// Package for the sync-framed packet parser: phase codes, status codes,
// configuration indexes and the structs passed between the parser modules.
// No dependencies.
`default_nettype none

package sfpp_pkg;

  localparam logic [7:0] END_BYTE = 8'h03;

  localparam logic [7:0]  SYNC_BYTE_RST   = 8'h01;
  localparam logic [2:0]  SYNC_NEEDED_RST = 3'd3;
  localparam logic [7:0]  FRAME_TYPE_RST  = 8'h45;
  localparam logic [15:0] MAX_LEN_RST     = 16'd256;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_TYPE = 3'd1,
    PH_CMD  = 3'd2,
    PH_LENH = 3'd3,
    PH_LENL = 3'd4,
    PH_DATA = 3'd5,
    PH_END  = 3'd6,
    PH_SUM  = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_BAD_END = 2'd2,
    ST_BAD_SUM = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_SYNC_BYTE   = 2'd0,
    CFG_SYNC_NEEDED = 2'd1,
    CFG_FRAME_TYPE  = 2'd2,
    CFG_MAX_LEN     = 2'd3
  } cfg_idx_t;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [7:0]  sync_byte;
    logic [2:0]  sync_needed;
    logic [7:0]  frame_type;
    logic [15:0] max_len;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [15:0] index;
    logic [7:0]  command;
    logic [15:0] frame_len;
    status_t     status;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/sfpp_fsm.sv
// Frame state machine of the sync-framed packet parser: holds the phase,
// sync count, checksum, command, length and byte counter, and forms one result.
// Depends on sfpp_pkg.
`default_nettype none

module sfpp_fsm
  import sfpp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  input  wire cfg_t       cfg,
  output logic            res_valid,
  output result_t         res
);

  phase_t      phase_r, phase_nxt;
  logic [2:0]  sync_count_r, sync_count_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [2:0]  sync_inc;
  logic [15:0] len_full;
  logic [15:0] cnt_inc;

  assign sync_inc = sync_count_r + 3'd1;
  assign len_full = {len_r[15:8], rx_byte};
  assign cnt_inc  = cnt_r + 16'd1;

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_HUNT: begin
        if ((rx_byte == cfg.sync_byte) && (sync_inc >= cfg.sync_needed)) begin
          phase_nxt = PH_TYPE;
        end
      end
      PH_TYPE: begin
        if (rx_byte == cfg.frame_type) begin
          phase_nxt = PH_CMD;
        end else if (rx_byte != cfg.sync_byte) begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_CMD:  phase_nxt = PH_LENH;
      PH_LENH: phase_nxt = PH_LENL;
      PH_LENL: begin
        if (len_full > cfg.max_len) begin
          phase_nxt = PH_HUNT;
        end else if (len_full == 16'd0) begin
          phase_nxt = PH_END;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        if (cnt_inc == len_r) begin
          phase_nxt = PH_END;
        end
      end
      PH_END:  phase_nxt = (rx_byte == END_BYTE) ? PH_SUM : PH_HUNT;
      PH_SUM:  phase_nxt = PH_HUNT;
      default: phase_nxt = PH_HUNT;
    endcase
  end

  always_comb begin
    sync_count_nxt = sync_count_r;
    sum_nxt        = sum_r;
    cmd_nxt        = cmd_r;
    len_nxt        = len_r;
    cnt_nxt        = cnt_r;
    res_valid      = 1'b0;
    res.kind       = KIND_STATUS;
    res.data       = 8'd0;
    res.index      = 16'd0;
    res.command    = cmd_r;
    res.frame_len  = len_r;
    res.status     = ST_OK;
    unique case (phase_r)
      PH_HUNT: begin
        if (rx_byte == cfg.sync_byte) begin
          sync_count_nxt = (sync_inc >= cfg.sync_needed) ? 3'd0 : sync_inc;
        end else begin
          sync_count_nxt = 3'd0;
        end
      end
      PH_TYPE: begin
        if (rx_byte == cfg.frame_type) begin
          sum_nxt = cfg.sync_byte + rx_byte;
        end
      end
      PH_CMD: begin
        sum_nxt = sum_r + rx_byte;
        cmd_nxt = rx_byte;
      end
      PH_LENH: begin
        sum_nxt = sum_r + rx_byte;
        len_nxt = {rx_byte, 8'd0};
      end
      PH_LENL: begin
        sum_nxt       = sum_r + rx_byte;
        len_nxt       = len_full;
        cnt_nxt       = 16'd0;
        res.frame_len = len_full;
        res.status    = ST_TOO_LONG;
        res_valid     = (len_full > cfg.max_len);
      end
      PH_DATA: begin
        sum_nxt   = sum_r + rx_byte;
        cnt_nxt   = cnt_inc;
        res_valid = 1'b1;
        res.kind  = KIND_DATA;
        res.data  = rx_byte;
        res.index = cnt_r;
      end
      PH_END: begin
        if (rx_byte == END_BYTE) begin
          sum_nxt = sum_r + rx_byte;
        end else begin
          res_valid  = 1'b1;
          res.status = ST_BAD_END;
        end
      end
      PH_SUM: begin
        res_valid  = 1'b1;
        res.status = (sum_r == rx_byte) ? ST_OK : ST_BAD_SUM;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      sync_count_r <= 3'd0;
      sum_r        <= 8'd0;
      cmd_r        <= 8'd0;
      len_r        <= 16'd0;
      cnt_r        <= 16'd0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      sync_count_r <= sync_count_nxt;
      sum_r        <= sum_nxt;
      cmd_r        <= cmd_nxt;
      len_r        <= len_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sync_framed_packet_parser_core.sv
// Top level of the sync-framed packet parser: input register, configuration
// registers, frame state machine and result register.
// Depends on sfpp_pkg and sfpp_fsm.
//
// The input channel (in_valid, in_stall, in_rx_byte) carries one received
// byte per item. The parser hunts for a run of sync bytes, checks the frame
// type, then takes the command, a big-endian 16-bit length, the payload, the
// end byte and an additive checksum. Each payload byte leaves on the result
// channel as a data item; one status item closes each frame whose type byte
// matched, including a frame dropped for a too large length.
// An accepted item is held in the input register until the result side can
// take it; the item is then processed and its result, if any, is loaded into
// the output register, which drives out_valid. One item is taken every cycle
// while the result side keeps up.
// When the receiver stalls a pending result, the input register holds its
// item and in_stall rises until the result is taken.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are taken
// in any cycle; cfg_ready is always high. Synchronous reset restores the
// register defaults, clears both pipeline valid flags and starts hunting.
`default_nettype none

module sync_framed_packet_parser_core
  import sfpp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_kind,
  output logic [7:0]       out_byte,
  output logic [15:0]      out_byte_index,
  output logic [7:0]       out_command,
  output logic [15:0]      out_frame_len,
  output logic [1:0]       out_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t       cfg_r;
  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       out_v_r;
  result_t    out_r;
  logic       advance;
  logic       res_valid;
  result_t    res;

  assign cfg_ready = 1'b1;
  assign advance   = in_v_r && (!out_v_r || !out_stall);
  assign in_stall  = in_v_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_byte   <= SYNC_BYTE_RST;
      cfg_r.sync_needed <= SYNC_NEEDED_RST;
      cfg_r.frame_type  <= FRAME_TYPE_RST;
      cfg_r.max_len     <= MAX_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SYNC_BYTE:   cfg_r.sync_byte   <= cfg_data[7:0];
        CFG_SYNC_NEEDED: cfg_r.sync_needed <= cfg_data[2:0];
        CFG_FRAME_TYPE:  cfg_r.frame_type  <= cfg_data[7:0];
        CFG_MAX_LEN:     cfg_r.max_len     <= cfg_data;
        default:         cfg_r.max_len     <= cfg_r.max_len;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_rx_byte;
    end
  end

  sfpp_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .rx_byte   (in_byte_r),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance && res_valid) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_v_r;
  assign out_kind       = out_r.kind;
  assign out_byte       = out_r.data;
  assign out_byte_index = out_r.index;
  assign out_command    = out_r.command;
  assign out_frame_len  = out_r.frame_len;
  assign out_status     = out_r.status;

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_stall && in_v_r) |-> in_stall)
    else $error("input stage advanced while a result was stalled");

  a_data_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_DATA)) |-> (out_status == ST_OK))
    else $error("payload item carries a nonzero status");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire
